@@ rtl/sclw_pkg.sv @@
// package for the sector cache lru writeback unit
// shared types, constants and controller/datapath command structs; no dependencies
`default_nettype none
package sclw_pkg;
	localparam int ENTRIES = 16;
	localparam int DEVICES = 4;
	localparam int SECTOR_BITS = 32;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int DEV_W = 2;
	localparam int CNT_W = 33;
	localparam int AGE_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W = 33;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_FLUSH = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_INVAL  = 2'd1,
		ST_WB_ERR = 2'd2,
		ST_RD_ERR = 2'd3
	} status_t;

	localparam logic [CFG_IDX_W-1:0] REG_RO   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_S512 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CNT0 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CNT3 = 3'd5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_MISS,
		S_FLUSH,
		S_FLUSH_END,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // capture request
		logic clear;       // wipe all entries
		logic scan_start;  // reset scan pointer and victim
		logic scan_step;   // examine one entry
		logic do_hit;      // update hit entry
		logic do_miss;     // resolve miss
		logic flush_step;  // examine one entry for flush
		logic emit_inval;  // emit invalid result
		logic emit_final;  // emit final ok result (flush end or clear)
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       is_flush;
		logic       is_clear;
		logic       invalid;
		logic       scan_end;
		logic       hit_found;
		logic       flush_stop;
	} dp_stat_t;
endpackage
`default_nettype wire

@@ rtl/sclw_ctrl.sv @@
// controller state machine of the sector cache unit
// depends on sclw_pkg
`default_nettype none
module sclw_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	output sclw_pkg::dp_cmd_t       cmd,
	input  wire sclw_pkg::dp_stat_t stat
);
	sclw_pkg::state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= sclw_pkg::S_IDLE;
		else state_q <= state_nx;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			sclw_pkg::S_IDLE: if (start) state_nx = sclw_pkg::S_CHECK;
			sclw_pkg::S_CHECK: begin
				if (stat.is_clear || stat.invalid) state_nx = sclw_pkg::S_DONE;
				else if (stat.is_flush) state_nx = sclw_pkg::S_FLUSH;
				else state_nx = sclw_pkg::S_SCAN;
			end
			sclw_pkg::S_SCAN: begin
				if (stat.hit_found) state_nx = sclw_pkg::S_DONE;
				else if (stat.scan_end) state_nx = sclw_pkg::S_MISS;
			end
			sclw_pkg::S_MISS: state_nx = sclw_pkg::S_DONE;
			sclw_pkg::S_FLUSH: begin
				if (stat.flush_stop) state_nx = sclw_pkg::S_DONE;
				else if (stat.scan_end) state_nx = sclw_pkg::S_FLUSH_END;
			end
			sclw_pkg::S_FLUSH_END: state_nx = sclw_pkg::S_DONE;
			sclw_pkg::S_DONE: state_nx = sclw_pkg::S_IDLE;
			default: state_nx = sclw_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		busy = (state_q != sclw_pkg::S_IDLE);
		case (state_q)
			sclw_pkg::S_IDLE: begin
				cmd.load = start;
				cmd.scan_start = start;
			end
			sclw_pkg::S_CHECK: begin
				cmd.clear = stat.is_clear;
				cmd.emit_final = stat.is_clear;
				cmd.emit_inval = stat.invalid;
			end
			sclw_pkg::S_SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.do_hit = stat.hit_found;
			end
			sclw_pkg::S_MISS: cmd.do_miss = 1'b1;
			sclw_pkg::S_FLUSH: cmd.flush_step = 1'b1;
			// final flush result is emitted from its own state after the walk
			sclw_pkg::S_FLUSH_END: cmd.emit_final = 1'b1;
			sclw_pkg::S_DONE: ;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

@@ rtl/sclw_dp.sv @@
// datapath of the sector cache unit: tags, ages, config and result register
// depends on sclw_pkg
`default_nettype none
module sclw_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [sclw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sclw_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic [1:0]                       in_cmd,
	input  wire logic [1:0]                       in_dev,
	input  wire logic [31:0]                      in_sector,
	input  wire logic                             in_wok,
	input  wire logic                             in_rok,
	input  wire sclw_pkg::dp_cmd_t                cmd,
	output sclw_pkg::dp_stat_t                    stat,
	output logic                                  done,
	output logic [1:0]                            status,
	output logic                                  hit,
	output logic [3:0]                            slot,
	output logic                                  writeback_valid,
	output logic [1:0]                            writeback_device,
	output logic [31:0]                           writeback_sector,
	output logic                                  fill_valid,
	output logic                                  last
);
	localparam int E = sclw_pkg::ENTRIES;
	localparam int IW = sclw_pkg::IDX_W;

	// configuration registers
	logic [3:0] ro_q, s512_q;
	logic [sclw_pkg::CNT_W-1:0] cnt_q [sclw_pkg::DEVICES];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ro_q <= '0;
			s512_q <= '0;
			for (int d = 0; d < sclw_pkg::DEVICES; d++) cnt_q[d] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sclw_pkg::REG_RO: ro_q <= cfg_data[3:0];
				sclw_pkg::REG_S512: s512_q <= cfg_data[3:0];
				default: begin
					if (cfg_index >= sclw_pkg::REG_CNT0 && cfg_index <= sclw_pkg::REG_CNT3)
						cnt_q[2'(cfg_index - sclw_pkg::REG_CNT0)] <= cfg_data;
				end
			endcase
		end
	end

	// captured request
	logic [1:0] rcmd_q, rdev_q;
	logic [31:0] rsec_q;
	logic wok_q, rok_q;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rcmd_q <= in_cmd;
			rdev_q <= in_dev;
			rsec_q <= in_sector;
			wok_q <= in_wok;
			rok_q <= in_rok;
		end
	end

	// entry state
	logic [E-1:0] val_q, dirty_q;
	logic [1:0] edev_q [E];
	logic [31:0] esec_q [E];
	logic [31:0] eage_q [E];
	logic [31:0] agec_q;

	// scan pointer and victim
	logic [IW:0] ptr_q;
	logic [IW-1:0] vic_q, p;
	logic scan_cmp_q;
	assign p = ptr_q[IW-1:0];

	// request validity
	logic invalid;
	assign invalid = !s512_q[rdev_q] || ({1'b0, rsec_q} >= cnt_q[rdev_q]) ||
		(rcmd_q == sclw_pkg::CMD_WRITE && ro_q[rdev_q]);

	logic match, better, fl_hit, fl_ok, vic_ok;
	assign match = val_q[p] && edev_q[p] == rdev_q && esec_q[p] == rsec_q;
	assign better = !val_q[p] || (val_q[vic_q] && eage_q[p] < eage_q[vic_q]);
	assign fl_hit = val_q[p] && dirty_q[p] && edev_q[p] == rdev_q;
	assign fl_ok = wok_q && !ro_q[edev_q[p]] && ({1'b0, esec_q[p]} < cnt_q[edev_q[p]]);
	assign vic_ok = wok_q && !ro_q[edev_q[vic_q]] &&
		({1'b0, esec_q[vic_q]} < cnt_q[edev_q[vic_q]]);

	logic [31:0] age_nx;
	assign age_nx = agec_q + 32'd1;
	logic vwb;
	assign vwb = val_q[vic_q] && dirty_q[vic_q];

	always_comb begin
		stat.is_flush = (rcmd_q == sclw_pkg::CMD_FLUSH);
		stat.is_clear = (rcmd_q == sclw_pkg::CMD_CLEAR);
		stat.invalid = !stat.is_flush && !stat.is_clear && invalid;
		stat.scan_end = (ptr_q == (IW+1)'(E - 1));
		stat.hit_found = match;
		stat.flush_stop = fl_hit && !fl_ok;
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			dirty_q <= '0;
			agec_q <= '0;
			ptr_q <= '0;
			vic_q <= '0;
			for (int i = 0; i < E; i++) begin
				edev_q[i] <= '0;
				esec_q[i] <= '0;
				eage_q[i] <= '0;
			end
		end else begin
			if (cmd.scan_start) begin
				ptr_q <= '0;
				vic_q <= '0;
			end
			if (cmd.clear) begin
				val_q <= '0;
				dirty_q <= '0;
				agec_q <= '0;
				for (int i = 0; i < E; i++) begin
					edev_q[i] <= '0;
					esec_q[i] <= '0;
					eage_q[i] <= '0;
				end
			end
			if (cmd.scan_step) begin
				ptr_q <= ptr_q + 1'b1;
				if (better) vic_q <= p;
			end
			if (cmd.do_hit) begin
				eage_q[p] <= age_nx;
				agec_q <= age_nx;
				if (rcmd_q == sclw_pkg::CMD_WRITE) dirty_q[p] <= 1'b1;
			end
			if (cmd.do_miss && !(vwb && !vic_ok)) begin
				val_q[vic_q] <= (rcmd_q == sclw_pkg::CMD_WRITE) || rok_q;
				dirty_q[vic_q] <= (rcmd_q == sclw_pkg::CMD_WRITE);
				edev_q[vic_q] <= rdev_q;
				esec_q[vic_q] <= rsec_q;
				eage_q[vic_q] <= age_nx;
				agec_q <= age_nx;
			end
			if (cmd.flush_step) begin
				ptr_q <= ptr_q + 1'b1;
				if (fl_hit && fl_ok) dirty_q[p] <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= cmd.emit_inval || cmd.emit_final || cmd.do_hit || cmd.do_miss ||
			(cmd.flush_step && fl_hit);
	end
	always_ff @(posedge clk) begin
		status <= sclw_pkg::ST_OK;
		hit <= 1'b0;
		slot <= '0;
		writeback_valid <= 1'b0;
		writeback_device <= '0;
		writeback_sector <= '0;
		fill_valid <= 1'b0;
		last <= 1'b1;
		if (cmd.emit_inval) status <= sclw_pkg::ST_INVAL;
		if (cmd.do_hit) begin
			hit <= 1'b1;
			slot <= 4'(p);
		end
		if (cmd.do_miss) begin
			slot <= 4'(vic_q);
			writeback_valid <= vwb;
			writeback_device <= vwb ? edev_q[vic_q] : 2'd0;
			writeback_sector <= vwb ? esec_q[vic_q] : 32'd0;
			if (vwb && !vic_ok) status <= sclw_pkg::ST_WB_ERR;
			else if (rcmd_q == sclw_pkg::CMD_READ) begin
				fill_valid <= 1'b1;
				if (!rok_q) status <= sclw_pkg::ST_RD_ERR;
			end
		end
		if (cmd.flush_step && fl_hit) begin
			slot <= 4'(p);
			writeback_valid <= 1'b1;
			writeback_device <= edev_q[p];
			writeback_sector <= esec_q[p];
			status <= fl_ok ? sclw_pkg::ST_OK : sclw_pkg::ST_WB_ERR;
			last <= !fl_ok;
		end
	end
endmodule
`default_nettype wire

@@ rtl/sector_cache_lru_writeback_unit.sv @@
// read/write hits and misses come from a sequential tag scan, one entry a cycle
// throughput: one request at a time, next start accepted once busy falls
// results are strobed by done for one cycle each; the receiver cannot stall
// reset clears all entries, the age counter and the configuration registers
// top level: joins sclw_ctrl and sclw_dp, depends on sclw_pkg
`default_nettype none
module sector_cache_lru_writeback_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [1:0]                     cmd,
	input  wire logic [1:0]                     device_id,
	input  wire logic [31:0]                    sector,
	input  wire logic                           backing_write_ok,
	input  wire logic                           backing_read_ok,
	input  wire logic                           cfg_we,
	input  wire logic [sclw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sclw_pkg::CFG_W-1:0]     cfg_data,
	output logic                                done,
	output logic [1:0]                          status,
	output logic                                hit,
	output logic [3:0]                          slot,
	output logic                                writeback_valid,
	output logic [1:0]                          writeback_device,
	output logic [31:0]                         writeback_sector,
	output logic                                fill_valid,
	output logic                                last
);
	sclw_pkg::dp_cmd_t dcmd;
	sclw_pkg::dp_stat_t dstat;

	sclw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(dcmd), .stat(dstat)
	);

	sclw_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_cmd(cmd), .in_dev(device_id), .in_sector(sector),
		.in_wok(backing_write_ok), .in_rok(backing_read_ok), .cmd(dcmd), .stat(dstat),
		.done(done), .status(status), .hit(hit), .slot(slot),
		.writeback_valid(writeback_valid), .writeback_device(writeback_device),
		.writeback_sector(writeback_sector), .fill_valid(fill_valid), .last(last)
	);

`ifndef SYNTHESIS
	// a hit result never carries a writeback or fill
	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> !writeback_valid && !fill_valid) else $error("hit with side traffic");
	// an item's last result ends the busy period
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done && last |=> !busy) else $error("busy after last result");
	// a new request is never taken while results are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last |-> busy) else $error("result outside request");
`endif
endmodule
`default_nettype wire
